/* sv/hwgc_pkg.sv */
// ----------------------------------------------------------------------------
// hwgc_pkg
// Shared types and constants for the hit time-window gap cleaner.
// ----------------------------------------------------------------------------
`default_nettype none

package hwgc_pkg;

  // Field widths of the request and result items
  localparam int unsigned ID_W      = 13;
  localparam int unsigned FTIME_W   = 24;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 24;
  localparam int unsigned WB_W      = 24;
  localparam int unsigned WA_W      = 23;
  localparam int unsigned GAP_W     = 24;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_BEFORE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_AFTER  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_THR    = 2'd2;

  // Register reset values
  localparam logic [WB_W-1:0]  WIN_BEFORE_RST = 24'hFFEED0; // -4400
  localparam logic [WA_W-1:0]  WIN_AFTER_RST  = 23'd6400;
  localparam logic [GAP_W-1:0] GAP_THR_RST    = 24'd10000;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_KEPT    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_REF  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_SURV = 2'd2;

  // Control sequencer
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_EMIT  = 4'b0100,
    S_FINAL = 4'b1000
  } state_e;

endpackage

`default_nettype wire

/* sv/hwgc_hit_mem.sv */
// ----------------------------------------------------------------------------
// hwgc_hit_mem
// Hit store: sensor ids and times, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module hwgc_hit_mem
  import hwgc_pkg::*;
#(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned TIME_W = 24,
  parameter int unsigned AW     = 6
) (
  input  wire logic              clk_i,
  input  wire logic              wr_en_i,
  input  wire logic [AW-1:0]     wr_addr_i,
  input  wire logic [ID_W-1:0]   wr_id_i,
  input  wire logic [TIME_W-1:0] wr_time_i,
  input  wire logic [AW-1:0]     rd_addr_i,
  output logic      [ID_W-1:0]   rd_id_o,
  output logic      [TIME_W-1:0] rd_time_o
);

  logic [ID_W-1:0]   id_mem   [DEPTH];
  logic [TIME_W-1:0] time_mem [DEPTH];

  // Write and synchronous read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      id_mem[wr_addr_i]   <= wr_id_i;
      time_mem[wr_addr_i] <= wr_time_i;
    end
    rd_id_o   <= id_mem[rd_addr_i];
    rd_time_o <= time_mem[rd_addr_i];
  end

endmodule

`default_nettype wire

/* sv/hit_time_window_gap_cleaner_unit.sv */
// ----------------------------------------------------------------------------
// hit_time_window_gap_cleaner_unit
// Windows one event's hits around the reference time, cuts early hits behind
// the latest large time gap before the reference, emits survivors in order.
// ----------------------------------------------------------------------------
// Usage:
//   Hits enter on the in_* channel, one per cycle while the unit is loading.
//   The request with last_hit set closes the event; the unit then stops
//   taking hits until the last result of the event is loaded into out_*.
//   Registers are written on the cfg_* channel, always ready; the user must
//   write them only while idle, which the unit does not enforce.
// Sequence:
//   End of event: scan passes over the n stored hits, one hit store read
//   per cycle, each find the next lower distinct kept time below the
//   reference, until one finds none or a large gap (n+1 passes at most);
//   then an emit pass reads each stored hit, then the final result.
// Reset:
//   Clears the event counters and loads the register defaults; the hit store
//   is not cleared, entries are only used after being written.
// Stall:
//   A stalled receiver holds the output register; the emit pass waits.
// ----------------------------------------------------------------------------
`default_nettype none

module hit_time_window_gap_cleaner_unit
  import hwgc_pkg::*;
#(
  parameter int unsigned MAX_HITS  = 64,
  parameter int unsigned TIME_BITS = 24
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  // hits
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [ID_W-1:0]      detector_id_i,
  input  wire logic [FTIME_W-1:0]   hit_time_i,
  input  wire logic                 is_reference_i,
  input  wire logic                 last_hit_i,
  // results
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic      [ID_W-1:0]      kept_id_o,
  output logic      [FTIME_W-1:0]   kept_time_o,
  output logic      [STATUS_W-1:0]  status_o,
  output logic                      overflow_o,
  output logic                      last_result_o
);

  localparam int unsigned AW = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
  localparam int unsigned CW = $clog2(MAX_HITS + 1);
  localparam int unsigned GW = (TIME_BITS > GAP_W) ? TIME_BITS : GAP_W;
  localparam int unsigned DW = GW + 2;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_HITS);

  state_e state_q, state_d;

  logic [WB_W-1:0]  win_before_q;
  logic [WA_W-1:0]  win_after_q;
  logic [GAP_W-1:0] gap_thr_q;

  logic [CW-1:0]        hit_count_q, hit_count_d;
  logic [TIME_BITS-1:0] ref_time_q, ref_time_d;
  logic                 ref_seen_q, ref_seen_d;
  logic                 ovf_q, ovf_d;

  logic [CW-1:0]        rd_idx_q, rd_idx_d;
  logic                 chk_vld_q, chk_vld_d;
  logic [TIME_BITS-1:0] cur_q, cur_d;
  logic [TIME_BITS-1:0] best_q, best_d;
  logic                 found_q, found_d;
  logic                 first_q, first_d;
  logic [TIME_BITS-1:0] cut_q, cut_d;
  logic                 has_cut_q, has_cut_d;
  logic [STATUS_W-1:0]  fin_status_q, fin_status_d;

  logic                 pend_vld_q, pend_vld_d;
  logic [ID_W-1:0]      pend_id_q, pend_id_d;
  logic [TIME_BITS-1:0] pend_time_q, pend_time_d;

  logic                 out_valid_q, out_valid_d;
  logic [ID_W-1:0]      out_id_q, out_id_d;
  logic [TIME_BITS-1:0] out_time_q, out_time_d;
  logic [STATUS_W-1:0]  out_status_q, out_status_d;
  logic                 out_ovf_q, out_ovf_d;
  logic                 out_last_q, out_last_d;

  logic                 in_acc;
  logic [TIME_BITS-1:0] t_in;
  logic                 wr_en;
  logic [AW-1:0]        rd_addr;
  logic [ID_W-1:0]      rd_id;
  logic [TIME_BITS-1:0] rd_time;
  logic                 out_free;
  logic                 in_window;
  logic                 survivor;
  logic                 pass_done;
  logic [GW-1:0]        gap;
  logic signed [DW-1:0] diff_s, before_s, after_s;

  assign t_in        = TIME_BITS'(hit_time_i);
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;
  assign wr_en       = in_acc && (hit_count_q < MAX_CNT);
  assign rd_addr     = rd_idx_q[AW-1:0];

  hwgc_hit_mem #(
    .DEPTH  (MAX_HITS),
    .TIME_W (TIME_BITS),
    .AW     (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (hit_count_q[AW-1:0]),
    .wr_id_i   (detector_id_i),
    .wr_time_i (t_in),
    .rd_addr_i (rd_addr),
    .rd_id_o   (rd_id),
    .rd_time_o (rd_time)
  );

  // Window and cut tests on the entry just read, gap and end of pass
  always_comb begin
    diff_s    = $signed(DW'(rd_time)) - $signed(DW'(ref_time_q));
    before_s  = DW'($signed(win_before_q));
    after_s   = $signed(DW'(win_after_q));
    in_window = (diff_s >= before_s) && (diff_s <= after_s);
    survivor  = in_window && (!has_cut_q || (rd_time >= cut_q));
    gap       = GW'(cur_q - best_q);
    pass_done = (rd_idx_q == hit_count_q) && !chk_vld_q;
  end

  // Sequencer: load, gap scan passes, emit pass, final result
  always_comb begin
    state_d      = state_q;
    hit_count_d  = hit_count_q;
    ref_time_d   = ref_time_q;
    ref_seen_d   = ref_seen_q;
    ovf_d        = ovf_q;
    rd_idx_d     = rd_idx_q;
    chk_vld_d    = 1'b0;
    cur_d        = cur_q;
    best_d       = best_q;
    found_d      = found_q;
    first_d      = first_q;
    cut_d        = cut_q;
    has_cut_d    = has_cut_q;
    fin_status_d = fin_status_q;
    pend_vld_d   = pend_vld_q;
    pend_id_d    = pend_id_q;
    pend_time_d  = pend_time_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_id_d     = out_id_q;
    out_time_d   = out_time_q;
    out_status_d = out_status_q;
    out_ovf_d    = out_ovf_q;
    out_last_d   = out_last_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (hit_count_q < MAX_CNT) begin
            hit_count_d = hit_count_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          if (is_reference_i) begin
            ref_time_d = t_in;
            ref_seen_d = 1'b1;
          end
          if (last_hit_i) begin
            rd_idx_d  = '0;
            found_d   = 1'b0;
            first_d   = 1'b1;
            has_cut_d = 1'b0;
            cur_d     = is_reference_i ? t_in : ref_time_q;
            if (is_reference_i || ref_seen_q) begin
              state_d = S_SCAN;
            end else begin
              fin_status_d = ST_NO_REF;
              state_d      = S_FINAL;
            end
          end
        end
      end

      S_SCAN: begin
        // largest kept time strictly below cur
        if (rd_idx_q != hit_count_q) begin
          rd_idx_d  = rd_idx_q + 1'b1;
          chk_vld_d = 1'b1;
        end
        if (chk_vld_q && in_window && (rd_time < cur_q) &&
            (!found_q || (rd_time > best_q))) begin
          best_d  = rd_time;
          found_d = 1'b1;
        end
        if (pass_done) begin
          rd_idx_d = '0;
          found_d  = 1'b0;
          first_d  = 1'b0;
          if (!found_q) begin
            state_d = S_EMIT;
          end else if (!first_q && (gap > GW'(gap_thr_q))) begin
            has_cut_d = 1'b1;
            cut_d     = cur_q;
            state_d   = S_EMIT;
          end else begin
            cur_d = best_q;
          end
        end
      end

      S_EMIT: begin
        // read issued when chk_vld_q is low, checked on the next cycle
        if (!chk_vld_q) begin
          chk_vld_d = 1'b1;
        end else if (!survivor || !pend_vld_q || out_free) begin
          if (survivor) begin
            if (pend_vld_q) begin
              out_valid_d  = 1'b1;
              out_id_d     = pend_id_q;
              out_time_d   = pend_time_q;
              out_status_d = ST_KEPT;
              out_ovf_d    = ovf_q;
              out_last_d   = 1'b0;
            end
            pend_vld_d  = 1'b1;
            pend_id_d   = rd_id;
            pend_time_d = rd_time;
          end
          rd_idx_d = rd_idx_q + 1'b1;
          if (rd_idx_q + 1'b1 >= hit_count_q) begin
            fin_status_d = ST_NO_SURV;
            state_d      = S_FINAL;
          end
        end else begin
          chk_vld_d = 1'b1;
        end
      end

      S_FINAL: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_id_d     = pend_vld_q ? pend_id_q : '0;
          out_time_d   = pend_vld_q ? pend_time_q : '0;
          out_status_d = pend_vld_q ? ST_KEPT : fin_status_q;
          out_ovf_d    = ovf_q;
          out_last_d   = 1'b1;
          pend_vld_d   = 1'b0;
          hit_count_d  = '0;
          ref_time_d   = '0;
          ref_seen_d   = 1'b0;
          ovf_d        = 1'b0;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      win_before_q <= WIN_BEFORE_RST;
      win_after_q  <= WIN_AFTER_RST;
      gap_thr_q    <= GAP_THR_RST;
      hit_count_q  <= '0;
      ref_time_q   <= '0;
      ref_seen_q   <= 1'b0;
      ovf_q        <= 1'b0;
      rd_idx_q     <= '0;
      chk_vld_q    <= 1'b0;
      found_q      <= 1'b0;
      first_q      <= 1'b0;
      has_cut_q    <= 1'b0;
      pend_vld_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      hit_count_q <= hit_count_d;
      ref_time_q  <= ref_time_d;
      ref_seen_q  <= ref_seen_d;
      ovf_q       <= ovf_d;
      rd_idx_q    <= rd_idx_d;
      chk_vld_q   <= chk_vld_d;
      found_q     <= found_d;
      first_q     <= first_d;
      has_cut_q   <= has_cut_d;
      pend_vld_q  <= pend_vld_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_WIN_BEFORE: win_before_q <= cfg_data_i;
          CFG_WIN_AFTER:  win_after_q  <= cfg_data_i[WA_W-1:0];
          CFG_GAP_THR:    gap_thr_q    <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cur_q        <= cur_d;
    best_q       <= best_d;
    cut_q        <= cut_d;
    fin_status_q <= fin_status_d;
    pend_id_q    <= pend_id_d;
    pend_time_q  <= pend_time_d;
    out_id_q     <= out_id_d;
    out_time_q   <= out_time_d;
    out_status_q <= out_status_d;
    out_ovf_q    <= out_ovf_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign kept_id_o     = out_id_q;
  assign kept_time_o   = FTIME_W'(out_time_q);
  assign status_o      = out_status_q;
  assign overflow_o    = out_ovf_q;
  assign last_result_o = out_last_q;

  // Checks
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("sequencer state not one-hot");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_count_q <= MAX_CNT) else $error("hit count beyond capacity");

  a_pend_only_late: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_vld_q |-> (state_q == S_EMIT || state_q == S_FINAL))
    else $error("pending result outside emit");

  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && last_hit_i) |=> !in_ready_o)
    else $error("hit taken while event in progress");

endmodule

`default_nettype wire

/* test/hwgc_checker.sv */
// ----------------------------------------------------------------------------
// hwgc_checker
// Watches the config, hit and result channels, predicts the survivors of each
// event and compares every result request field by field with the oldest one.
// ----------------------------------------------------------------------------
module hwgc_checker
  import hwgc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]    cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [ID_W-1:0]     detector_id_i,
  input  logic [FTIME_W-1:0]  hit_time_i,
  input  logic                is_reference_i,
  input  logic                last_hit_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [ID_W-1:0]     kept_id_i,
  input  logic [FTIME_W-1:0]  kept_time_i,
  input  logic [STATUS_W-1:0] status_i,
  input  logic                overflow_i,
  input  logic                last_result_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  localparam int CAP = 64;

  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [FTIME_W-1:0]  t;
    logic [STATUS_W-1:0] st;
    logic                ovf;
    logic                last;
  } survivor_t;

  survivor_t survivor_q[$];

  logic [WB_W-1:0]    win_before;
  logic [WA_W-1:0]    win_after;
  logic [GAP_W-1:0]   gap_thr;
  logic [ID_W-1:0]    ev_ids[CAP];
  logic [FTIME_W-1:0] ev_times[CAP];
  int                 ev_count;
  logic [FTIME_W-1:0] ref_time;
  logic               ref_seen;
  logic               ev_ovf;

  // Append one expected result
  task automatic add_result(input survivor_t r);
    survivor_q = {survivor_q, r};
  endtask

  // Close an event: window, sort, gap cut, queue survivors or a status result
  task automatic close_event();
    bit           keep[CAP];
    longint       srt[CAP];
    longint       d, lo, cut;
    int           n, j, cnt;
    bit           has_cut;
    survivor_t    r;
    n = 0; cnt = 0; has_cut = 1'b0; cut = 0;
    if (!ref_seen) begin
      r = '{id: '0, t: '0, st: ST_NO_REF, ovf: ev_ovf, last: 1'b1};
      add_result(r);
    end else begin
      lo = longint'($signed(win_before));
      for (int i = 0; i < ev_count; i++) begin
        d = longint'(ev_times[i]) - longint'(ref_time);
        keep[i] = (d >= lo) && (d <= longint'(win_after));
        if (keep[i]) begin
          j = n;
          while (j > 0 && srt[j-1] > longint'(ev_times[i])) begin
            srt[j] = srt[j-1];
            j--;
          end
          srt[j] = longint'(ev_times[i]);
          n++;
        end
      end
      for (int i = 1; i < n; i++)
        if ((srt[i] - srt[i-1]) > longint'(gap_thr) && longint'(ref_time) > srt[i]) begin
          has_cut = 1'b1;
          cut = srt[i];
        end
      for (int i = 0; i < ev_count; i++)
        if (keep[i] && (!has_cut || longint'(ev_times[i]) >= cut)) begin
          r = '{id: ev_ids[i], t: ev_times[i], st: ST_KEPT, ovf: ev_ovf, last: 1'b0};
          add_result(r);
          cnt++;
        end
      if (cnt == 0) begin
        r = '{id: '0, t: '0, st: ST_NO_SURV, ovf: ev_ovf, last: 1'b1};
        add_result(r);
      end else begin
        survivor_q[$].last = 1'b1;
      end
    end
    ev_count = 0; ref_time = '0; ref_seen = 1'b0; ev_ovf = 1'b0;
  endtask

  assign pending_o = survivor_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    survivor_t exp_r;
    if (!rst_ni) begin
      win_before   <= WIN_BEFORE_RST;
      win_after    <= WIN_AFTER_RST;
      gap_thr      <= GAP_THR_RST;
      ev_count     = 0;
      ref_time     = '0;
      ref_seen     = 1'b0;
      ev_ovf       = 1'b0;
      fail_count_o <= 0;
    end else begin
      // register writes
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_WIN_BEFORE: win_before <= cfg_data_i[WB_W-1:0];
          CFG_WIN_AFTER:  win_after  <= cfg_data_i[WA_W-1:0];
          CFG_GAP_THR:    gap_thr    <= cfg_data_i[GAP_W-1:0];
          default: ;
        endcase
      end
      // result compare
      if (out_valid_i && out_ready_i) begin
        if (survivor_q.size() == 0) begin
          $display("%0t: unexpected result id=%0d time=%0d st=%0d", $time,
                   kept_id_i, kept_time_i, status_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = survivor_q.pop_front();
          if (exp_r !== {kept_id_i, kept_time_i, status_i, overflow_i, last_result_i}) begin
            $display("%0t: mismatch exp id=%0d time=%0d st=%0d ovf=%0d last=%0d",
                     $time, exp_r.id, exp_r.t, exp_r.st, exp_r.ovf, exp_r.last);
            $display("%0t:          act id=%0d time=%0d st=%0d ovf=%0d last=%0d",
                     $time, kept_id_i, kept_time_i, status_i, overflow_i, last_result_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      // hit load
      if (in_valid_i && in_ready_i) begin
        if (ev_count < CAP) begin
          ev_ids[ev_count]   = detector_id_i;
          ev_times[ev_count] = hit_time_i;
          ev_count++;
        end else begin
          ev_ovf = 1'b1;
        end
        if (is_reference_i) begin
          ref_time = hit_time_i;
          ref_seen = 1'b1;
        end
        if (last_hit_i) close_event();
      end
    end
  end

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives events of hits through the gap cleaner under random idling on both
// sides, across several register settings; the checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  import hwgc_pkg::*;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [ID_W-1:0]      detector_id_i = '0;
  logic [FTIME_W-1:0]   hit_time_i = '0;
  logic                 is_reference_i = 1'b0;
  logic                 last_hit_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [ID_W-1:0]      kept_id_o;
  logic [FTIME_W-1:0]   kept_time_o;
  logic [STATUS_W-1:0]  status_o;
  logic                 overflow_o;
  logic                 last_result_o;
  int                   fail_count;
  int                   pending;
  int                   hits_sent = 0;
  bit                   calm = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  hit_time_window_gap_cleaner_unit i_dut (.*);

  hwgc_checker i_checker (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .detector_id_i, .hit_time_i, .is_reference_i,
    .last_hit_i, .out_valid_i(out_valid_o), .out_ready_i, .kept_id_i(kept_id_o),
    .kept_time_i(kept_time_o), .status_i(status_o), .overflow_i(overflow_o),
    .last_result_i(last_result_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  // Receiver: bursts of stall, none in the last part
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        n = $urandom_range(1, 19);
        repeat (n) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  // One register write request; ready is looked at between edges
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    while (!cfg_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // One hit request, with an optional idle burst ahead of it
  task automatic send_hit(input logic [ID_W-1:0] id, input logic [FTIME_W-1:0] t,
                          input bit isref, input bit last);
    int n;
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      n = $urandom_range(1, 19);
      repeat (n) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    detector_id_i  <= id;
    hit_time_i     <= t;
    is_reference_i <= isref;
    last_hit_i     <= last;
    // ready only moves at rising edges, so it is stable here
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    hits_sent++;
  endtask

  task automatic release_hit();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // Wait until every queued result has come out
  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // A realistic event: clustered times, early stragglers and random times; most carry a reference
  task automatic random_event(input int nhits, input int spread);
    logic [FTIME_W-1:0] base, t;
    int                 refpos, mode;
    base   = FTIME_W'($urandom_range(20000, 16757215));
    refpos = $urandom_range(0, nhits - 1);
    mode   = $urandom_range(0, 9);
    for (int i = 0; i < nhits; i++) begin
      case ($urandom_range(0, 5))
        0:       t = FTIME_W'(base - $urandom_range(0, 3 * spread));
        1:       t = FTIME_W'($urandom());
        default: t = FTIME_W'(base + $urandom_range(0, spread) - spread / 2);
      endcase
      send_hit(ID_W'($urandom()), t,
               (mode == 0) ? 1'b0 : ((i == refpos) || ($urandom_range(0, 15) == 0)),
               i == nhits - 1);
    end
    release_hit();
  endtask

  initial begin
    int nh;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: field extremes, no reference, equal times
    send_hit(13'h1FFF, 24'hFFFFFF, 1, 1);
    send_hit(13'd0, 24'd0, 0, 1);
    send_hit(13'd5, 24'd100000, 0, 0);
    send_hit(13'd6, 24'd100000, 1, 0);
    send_hit(13'd7, 24'd80000, 0, 0);
    send_hit(13'd8, 24'd97000, 0, 0);
    send_hit(13'd9, 24'd84000, 0, 0);
    send_hit(13'd10, 24'd104000, 0, 1);
    send_hit(13'd1, 24'd500, 1, 0);
    send_hit(13'd2, 24'd600, 1, 1);
    release_hit();
    drain();
    write_reg(CFG_WIN_BEFORE, 24'd0);
    write_reg(CFG_WIN_AFTER, 24'd0);
    write_reg(CFG_GAP_THR, 24'd0);
    send_hit(13'd3, 24'd1000, 0, 0);
    send_hit(13'd4, 24'd1001, 1, 0);
    send_hit(13'd4, 24'd1001, 0, 1);
    send_hit(13'd11, 24'd1000, 0, 0);
    send_hit(13'd12, 24'd2000, 1, 1);
    release_hit();
    drain();
    // Widest window, overflow event
    write_reg(CFG_WIN_BEFORE, 24'h800000);
    write_reg(CFG_WIN_AFTER, 24'h7FFFFF);
    write_reg(CFG_GAP_THR, 24'hFFFFFF);
    for (int i = 0; i < 70; i++) send_hit(ID_W'(i), FTIME_W'($urandom()), i == 68, i == 69);
    release_hit();
    drain();

    // Random phases over several settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_WIN_BEFORE, WIN_BEFORE_RST);
          write_reg(CFG_WIN_AFTER, CFG_W'(WIN_AFTER_RST));
          write_reg(CFG_GAP_THR, GAP_THR_RST);
        end
        1: begin
          write_reg(CFG_WIN_BEFORE, -24'sd20000);
          write_reg(CFG_WIN_AFTER, 24'd20000);
          write_reg(CFG_GAP_THR, 24'd300);
        end
        2: begin
          write_reg(CFG_WIN_BEFORE, 24'h800000);
          write_reg(CFG_WIN_AFTER, 24'h7FFFFF);
          write_reg(CFG_GAP_THR, 24'd2000);
        end
        default: begin
          write_reg(CFG_WIN_BEFORE, CFG_W'($urandom()));
          write_reg(CFG_WIN_AFTER, CFG_W'($urandom()));
          write_reg(CFG_GAP_THR, CFG_W'($urandom_range(0, 20000)));
        end
      endcase
      calm = (ph == 5);
      for (int e = 0; e < 9; e++) begin
        nh = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 66) : $urandom_range(1, 6);
        random_event(nh, $urandom_range(100, 30000));
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #40000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
